>>> src/cbs_pkg.sv
// Shared types and constants of the cubic Bezier split pipeline.
`timescale 1ns / 1ps

package cbs_pkg;

  // Coordinate and split parameter formats
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned PARAM_W    = FRAC_BITS + 1;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned PROD_W     = DIFF_W + PARAM_W + 1;

  // Pipeline shape: three interpolation levels of three stages each
  localparam int unsigned LERP_STAGES = 3;
  localparam int unsigned LEVELS      = 3;
  localparam int unsigned NUM_STAGES  = LERP_STAGES * LEVELS;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] handle_a_x;
    logic signed [COORD_W-1:0] handle_a_y;
    logic signed [COORD_W-1:0] handle_b_x;
    logic signed [COORD_W-1:0] handle_b_y;
    logic signed [COORD_W-1:0] finish_x;
    logic signed [COORD_W-1:0] finish_y;
    logic        [PARAM_W-1:0] split_param;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_h1_x;
    logic signed [COORD_W-1:0] left_h1_y;
    logic signed [COORD_W-1:0] left_h2_x;
    logic signed [COORD_W-1:0] left_h2_y;
    logic signed [COORD_W-1:0] split_x;
    logic signed [COORD_W-1:0] split_y;
    logic signed [COORD_W-1:0] right_h1_x;
    logic signed [COORD_W-1:0] right_h1_y;
    logic signed [COORD_W-1:0] right_h2_x;
    logic signed [COORD_W-1:0] right_h2_y;
  } out_item_t;

  // Stage controls from the pipeline controller
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic                  out_valid;
  } pipe_ctrl_t;

endpackage

>>> src/cbs_in_if.sv
// Request channel carrying the control points and split parameter.
`timescale 1ns / 1ps

interface cbs_in_if;
  logic             valid;
  logic             ready;
  cbs_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/cbs_out_if.sv
// Result channel carrying the five new points of a split.
`timescale 1ns / 1ps

interface cbs_out_if;
  logic              valid;
  logic              ready;
  cbs_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/cbs_lerp.sv
// Three-stage rounded linear interpolation of one point: difference, product, sum.
`timescale 1ns / 1ps

module cbs_lerp (
  input  logic                          clk_i,
  input  logic [cbs_pkg::LERP_STAGES-1:0] en_i,
  input  cbs_pkg::point_t               a_i,
  input  cbs_pkg::point_t               b_i,
  input  logic [cbs_pkg::PARAM_W-1:0]   t_i,
  output cbs_pkg::point_t               r_o
);

  cbs_pkg::point_t                     a1_q, a2_q, r_q;
  logic signed [cbs_pkg::DIFF_W-1:0]   dx_q, dy_q;
  logic        [cbs_pkg::PARAM_W-1:0]  t1_q;
  logic signed [cbs_pkg::PROD_W-1:0]   px_q, py_q;

  // Take the difference b - a one bit wider
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a1_q <= a_i;
      t1_q <= t_i;
      dx_q <= $signed({b_i.x[cbs_pkg::COORD_W-1], b_i.x})
            - $signed({a_i.x[cbs_pkg::COORD_W-1], a_i.x});
      dy_q <= $signed({b_i.y[cbs_pkg::COORD_W-1], b_i.y})
            - $signed({a_i.y[cbs_pkg::COORD_W-1], a_i.y});
    end
  end

  // Scale by t and add half an LSB for rounding
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      a2_q <= a1_q;
      px_q <= cbs_pkg::PROD_W'(dx_q) * cbs_pkg::PROD_W'($signed({1'b0, t1_q}))
            + cbs_pkg::ROUND_HALF;
      py_q <= cbs_pkg::PROD_W'(dy_q) * cbs_pkg::PROD_W'($signed({1'b0, t1_q}))
            + cbs_pkg::ROUND_HALF;
    end
  end

  // Drop the fraction (floor) and add back the base point
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      r_q.x <= cbs_pkg::COORD_W'(cbs_pkg::PROD_W'(a2_q.x)
                                 + (px_q >>> cbs_pkg::FRAC_BITS));
      r_q.y <= cbs_pkg::COORD_W'(cbs_pkg::PROD_W'(a2_q.y)
                                 + (py_q >>> cbs_pkg::FRAC_BITS));
    end
  end

  assign r_o = r_q;

endmodule

>>> src/cbs_ctrl.sv
// Valid bits and per-stage advance enables of the split pipeline.
`timescale 1ns / 1ps

module cbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output cbs_pkg::pipe_ctrl_t ctrl_o
);

  logic [cbs_pkg::NUM_STAGES-1:0] valid_q, valid_d, en;

  // Advance a stage when it is empty or the next stage advances
  always_comb begin
    en[cbs_pkg::NUM_STAGES-1] = !valid_q[cbs_pkg::NUM_STAGES-1] || out_ready_i;
    for (int i = cbs_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  // Shift valid bits along with the data, hold where stalled
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int i = 1; i < cbs_pkg::NUM_STAGES; i++) begin
      if (en[i]) begin
        valid_d[i] = valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o       = en[0];
  assign ctrl_o.en        = en;
  assign ctrl_o.out_valid = valid_q[cbs_pkg::NUM_STAGES-1];

endmodule

>>> src/cubic_bezier_split.sv
// Top level of the cubic Bezier split pipeline.
//
// Splits a planar cubic Bezier at parameter t by de Casteljau subdivision.
// Request channel in_i carries the start point, two handles, the finish
// point (signed Q23.8) and split_param (unsigned Q1.16, 65536 means one;
// larger values act as one). Result channel out_o carries the left half's
// two handles, the split point and the right half's two handles.
// Both channels use valid/ready; a request moves when both are high.
// A request passes three interpolation levels, each a difference, a
// product with rounding half and a floor-and-sum stage.
// Throughput is one request per cycle while the receiver does not stall; every stage holds one request.
// When the receiver stalls, the pipeline fills up stage by stage and
// in_i.ready falls only once every stage holds a request; nothing is lost
// or repeated. Reset clears all valid bits; the data path has no reset.
`timescale 1ns / 1ps

module cubic_bezier_split (
  input  logic         clk_i,
  input  logic         rst_ni,
  cbs_in_if.sink       in_i,
  cbs_out_if.source    out_o
);

  localparam int unsigned L1_END = cbs_pkg::LERP_STAGES;      // first stage of level 2
  localparam int unsigned L2_END = 2 * cbs_pkg::LERP_STAGES;  // first stage of level 3
  localparam int unsigned HOLD1  = cbs_pkg::NUM_STAGES - L1_END;
  localparam int unsigned HOLD2  = cbs_pkg::NUM_STAGES - L2_END;

  cbs_pkg::pipe_ctrl_t           ctrl;
  logic [cbs_pkg::PARAM_W-1:0]   t_sat;
  logic [cbs_pkg::PARAM_W-1:0]   t_q [L2_END];
  cbs_pkg::point_t               p1, p2, p3, p4;
  cbs_pkg::point_t               p12, p23, p34, p123, p234, p1234;
  cbs_pkg::point_t               p12_q [HOLD1];
  cbs_pkg::point_t               p34_q [HOLD1];
  cbs_pkg::point_t               p123_q [HOLD2];
  cbs_pkg::point_t               p234_q [HOLD2];

  cbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_ready_i(out_o.ready),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  // Clamp t to one and unpack the control points
  assign t_sat = (in_i.payload.split_param > cbs_pkg::PARAM_ONE) ?
                 cbs_pkg::PARAM_ONE : in_i.payload.split_param;
  assign p1 = '{x: in_i.payload.start_x,    y: in_i.payload.start_y};
  assign p2 = '{x: in_i.payload.handle_a_x, y: in_i.payload.handle_a_y};
  assign p3 = '{x: in_i.payload.handle_b_x, y: in_i.payload.handle_b_y};
  assign p4 = '{x: in_i.payload.finish_x,   y: in_i.payload.finish_y};

  // Carry t alongside the first two levels
  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) begin
      t_q[0] <= t_sat;
    end
    for (int i = 1; i < L2_END; i++) begin
      if (ctrl.en[i]) begin
        t_q[i] <= t_q[i-1];
      end
    end
  end

  // Level one: the three control polygon edges
  cbs_lerp u_l12 (.clk_i(clk_i), .en_i(ctrl.en[L1_END-1:0]),
                  .a_i(p1), .b_i(p2), .t_i(t_sat), .r_o(p12));
  cbs_lerp u_l23 (.clk_i(clk_i), .en_i(ctrl.en[L1_END-1:0]),
                  .a_i(p2), .b_i(p3), .t_i(t_sat), .r_o(p23));
  cbs_lerp u_l34 (.clk_i(clk_i), .en_i(ctrl.en[L1_END-1:0]),
                  .a_i(p3), .b_i(p4), .t_i(t_sat), .r_o(p34));

  // Level two: the inner handles
  cbs_lerp u_l123 (.clk_i(clk_i), .en_i(ctrl.en[L2_END-1:L1_END]),
                   .a_i(p12), .b_i(p23), .t_i(t_q[L1_END-1]), .r_o(p123));
  cbs_lerp u_l234 (.clk_i(clk_i), .en_i(ctrl.en[L2_END-1:L1_END]),
                   .a_i(p23), .b_i(p34), .t_i(t_q[L1_END-1]), .r_o(p234));

  // Level three: the split point on the curve
  cbs_lerp u_l1234 (.clk_i(clk_i), .en_i(ctrl.en[cbs_pkg::NUM_STAGES-1:L2_END]),
                    .a_i(p123), .b_i(p234), .t_i(t_q[L2_END-1]), .r_o(p1234));

  // Hold the outer handles until the split point is ready
  always_ff @(posedge clk_i) begin
    if (ctrl.en[L1_END]) begin
      p12_q[0] <= p12;
      p34_q[0] <= p34;
    end
    for (int i = 1; i < HOLD1; i++) begin
      if (ctrl.en[L1_END+i]) begin
        p12_q[i] <= p12_q[i-1];
        p34_q[i] <= p34_q[i-1];
      end
    end
  end

  // Hold the inner handles for the last level
  always_ff @(posedge clk_i) begin
    if (ctrl.en[L2_END]) begin
      p123_q[0] <= p123;
      p234_q[0] <= p234;
    end
    for (int i = 1; i < HOLD2; i++) begin
      if (ctrl.en[L2_END+i]) begin
        p123_q[i] <= p123_q[i-1];
        p234_q[i] <= p234_q[i-1];
      end
    end
  end

  // Pack the result
  assign out_o.valid              = ctrl.out_valid;
  assign out_o.payload.left_h1_x  = p12_q[HOLD1-1].x;
  assign out_o.payload.left_h1_y  = p12_q[HOLD1-1].y;
  assign out_o.payload.left_h2_x  = p123_q[HOLD2-1].x;
  assign out_o.payload.left_h2_y  = p123_q[HOLD2-1].y;
  assign out_o.payload.split_x    = p1234.x;
  assign out_o.payload.split_y    = p1234.y;
  assign out_o.payload.right_h1_x = p234_q[HOLD2-1].x;
  assign out_o.payload.right_h1_y = p234_q[HOLD2-1].y;
  assign out_o.payload.right_h2_x = p34_q[HOLD1-1].x;
  assign out_o.payload.right_h2_y = p34_q[HOLD1-1].y;

endmodule

>>> tb/tb_cubic_bezier_split.sv
// Self-checking testbench for the cubic Bezier split pipeline.
`timescale 1ns / 1ps

module tb_cubic_bezier_split;
  import cbs_pkg::*;

  localparam int     RANDOM_SPLITS  = 450;
  localparam int     HOLD_CYCLES    = 80;
  localparam int     DRAIN_CYCLES   = 20;
  localparam int     WATCHDOG_LIMIT = 1000;
  localparam int     CMAX           = 32'h7FFF_FFFF;
  localparam int     CMIN           = 32'h8000_0000;
  localparam longint T_UNIT         = longint'(1) << FRAC_BITS;
  localparam longint T_HALF         = longint'(1) << (FRAC_BITS - 1);

  // Expected halves typed in by hand, or left to the predictor
  typedef struct {
    bit        known;
    out_item_t want;
  } typed_half_t;

  typedef struct {
    in_item_t    stim;
    typed_half_t fixed;
  } split_row_t;

  logic clk_i;
  logic rst_ni;

  cbs_in_if  req_ch ();
  cbs_out_if res_ch ();

  out_item_t   expected_halves[$];
  typed_half_t typed_halves[$];
  split_row_t  split_table[$];

  int  items_sent;
  int  results_seen;
  int  mismatches;
  int  stall_cycles;
  int  saturated_splits;
  bit  hold_off;
  bit  no_idle;

  cubic_bezier_split DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Interpolate from a toward b by t, rounding to nearest, ties upward
  function automatic longint interp(longint a, longint b, longint t);
    return a + (((b - a) * t + T_HALF) >>> FRAC_BITS);
  endfunction

  // Run the three interpolation levels on one axis
  function automatic void split_axis(input longint p1, p2, p3, p4, t,
                                     output longint h1, h2, s, r1, r2);
    longint p23;
    h1  = interp(p1, p2, t);
    p23 = interp(p2, p3, t);
    r2  = interp(p3, p4, t);
    h2  = interp(h1, p23, t);
    r1  = interp(p23, r2, t);
    s   = interp(h2, r1, t);
  endfunction

  function automatic out_item_t split_curve(in_item_t c);
    longint    t;
    longint    h1, h2, s, r1, r2;
    out_item_t r;
    t = longint'(c.split_param);
    if (t > T_UNIT) t = T_UNIT;
    split_axis(longint'(c.start_x), longint'(c.handle_a_x), longint'(c.handle_b_x),
               longint'(c.finish_x), t, h1, h2, s, r1, r2);
    r.left_h1_x  = COORD_W'(h1);
    r.left_h2_x  = COORD_W'(h2);
    r.split_x    = COORD_W'(s);
    r.right_h1_x = COORD_W'(r1);
    r.right_h2_x = COORD_W'(r2);
    split_axis(longint'(c.start_y), longint'(c.handle_a_y), longint'(c.handle_b_y),
               longint'(c.finish_y), t, h1, h2, s, r1, r2);
    r.left_h1_y  = COORD_W'(h1);
    r.left_h2_y  = COORD_W'(h2);
    r.split_y    = COORD_W'(s);
    r.right_h1_y = COORD_W'(r1);
    r.right_h2_y = COORD_W'(r2);
    return r;
  endfunction

  function automatic in_item_t curve(int sx, sy, ax, ay, bx, by, fx, fy, int t);
    in_item_t c;
    c.start_x     = sx;
    c.start_y     = sy;
    c.handle_a_x  = ax;
    c.handle_a_y  = ay;
    c.handle_b_x  = bx;
    c.handle_b_y  = by;
    c.finish_x    = fx;
    c.finish_y    = fy;
    c.split_param = PARAM_W'(t);
    return c;
  endfunction

  function automatic out_item_t halves(int l1x, l1y, l2x, l2y, sx, sy,
                                       r1x, r1y, r2x, r2y);
    out_item_t r;
    r.left_h1_x  = l1x;
    r.left_h1_y  = l1y;
    r.left_h2_x  = l2x;
    r.left_h2_y  = l2y;
    r.split_x    = sx;
    r.split_y    = sy;
    r.right_h1_x = r1x;
    r.right_h1_y = r1y;
    r.right_h2_x = r2x;
    r.right_h2_y = r2y;
    return r;
  endfunction

  function automatic void add_row(in_item_t c, bit known, out_item_t want);
    split_row_t row;
    row.stim        = c;
    row.fixed.known = known;
    row.fixed.want  = want;
    split_table.push_back(row);
  endfunction

  // Full range, a tight cluster round a base, or an extreme
  function automatic int pick_coord(int style, int base);
    case (style)
      0: return int'($urandom);
      1: return base + int'($urandom_range(0, 8191)) - 4096;
      default: begin
        case ($urandom_range(0, 5))
          0: return CMAX;
          1: return CMIN;
          2: return 0;
          3: return -1;
          4: return 1;
          default: return int'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic int pick_param();
    int edges[5] = '{0, 1, 32768, 65535, 65536};
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(65537, 131071));
      1: return edges[$urandom_range(0, 4)];
      default: return int'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [COORD_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  task automatic compare_halves(input out_item_t want, got);
    check_field("left_h1_x", want.left_h1_x, got.left_h1_x);
    check_field("left_h1_y", want.left_h1_y, got.left_h1_y);
    check_field("left_h2_x", want.left_h2_x, got.left_h2_x);
    check_field("left_h2_y", want.left_h2_y, got.left_h2_y);
    check_field("split_x", want.split_x, got.split_x);
    check_field("split_y", want.split_y, got.split_y);
    check_field("right_h1_x", want.right_h1_x, got.right_h1_x);
    check_field("right_h1_y", want.right_h1_y, got.right_h1_y);
    check_field("right_h2_x", want.right_h2_x, got.right_h2_x);
    check_field("right_h2_y", want.right_h2_y, got.right_h2_y);
  endtask

  // Offer one request and hold it until the block takes it
  task automatic offer(input in_item_t c, input typed_half_t fixed);
    typed_halves.push_back(fixed);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= c;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
    if (c.split_param > PARAM_ONE) saturated_splits++;
  endtask

  // Random sender gap with valid low, skipped once no_idle is set
  task automatic maybe_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin : split_monitor
    typed_half_t fixed;
    out_item_t   want;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        fixed = typed_halves.pop_front();
        want  = fixed.known ? fixed.want : split_curve(req_ch.payload);
        expected_halves.push_back(want);
        moved = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        moved = 1'b1;
        results_seen++;
        if (expected_halves.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          compare_halves(expected_halves.pop_front(), res_ch.payload);
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("tb_cubic_bezier_split: done, errors");
    $finish;
  end

  // Result side: random short stalls, one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    res_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        if (!no_idle && stall_left == 0 && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 3);
        res_ch.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    typed_half_t unknown;
    int          style;
    int          base;
    unknown.known  = 1'b0;
    unknown.want   = '0;
    items_sent     = 0;
    results_seen   = 0;
    mismatches     = 0;
    stall_cycles   = 0;
    saturated_splits = 0;
    hold_off       = 1'b0;
    no_idle        = 1'b0;
    rst_ni         <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All zero, and the end cases of t on a plain curve
    add_row(curve(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, halves(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(curve(256, 512, 1024, -768, -2048, 4096, 8192, -256, 0), 1,
            halves(256, 512, 256, 512, 256, 512, 1024, -768, -2048, 4096));
    add_row(curve(256, 512, 1024, -768, -2048, 4096, 8192, -256, 65536), 1,
            halves(1024, -768, -2048, 4096, 8192, -256, 8192, -256, 8192, -256));
    // t above one acts as one
    add_row(curve(256, 512, 1024, -768, -2048, 4096, 8192, -256, 65537), 1,
            halves(1024, -768, -2048, 4096, 8192, -256, 8192, -256, 8192, -256));
    add_row(curve(256, 512, 1024, -768, -2048, 4096, 8192, -256, 131071), 1,
            halves(1024, -768, -2048, 4096, 8192, -256, 8192, -256, 8192, -256));
    // Degenerate curves at the coordinate extremes stay put
    add_row(curve(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 32768), 1,
            halves(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    add_row(curve(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 12345), 1,
            halves(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    // Midpoint of an evenly spaced zig-zag
    add_row(curve(0, 0, 256, 256, 512, 0, 768, 256, 32768), 1,
            halves(128, 128, 256, 128, 384, 128, 512, 128, 640, 128));
    // Full-swing zig-zags and rounding ties, left to the predictor
    add_row(curve(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 32768), 0, unknown.want);
    add_row(curve(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, 1), 0, unknown.want);
    add_row(curve(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 65535), 0, unknown.want);
    add_row(curve(0, 0, 1, -1, 0, 0, 1, -1, 32768), 0, unknown.want);
    add_row(curve(1, -1, 0, 0, -1, 1, 0, 0, 32768), 0, unknown.want);
    add_row(curve(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'h0FFFF), 0, unknown.want);
    add_row(curve(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                  int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                  21845), 0, unknown.want);

    foreach (split_table[i]) begin
      maybe_gap();
      offer(split_table[i].stim, split_table[i].fixed);
    end

    for (int n = 0; n < RANDOM_SPLITS; n++) begin
      if (n == 150) hold_off = 1'b1;
      if (n == 390) no_idle = 1'b1;
      if (n == 300) begin
        // Let the pipeline empty completely before going on
        req_ch.valid <= 1'b0;
        while (results_seen < items_sent) @(posedge clk_i);
      end else begin
        maybe_gap();
      end
      style = $urandom_range(0, 4);
      style = (style < 2) ? 0 : (style < 4) ? 1 : 2;
      base  = int'($urandom);
      offer(curve(pick_coord(style, base), pick_coord(style, base),
                  pick_coord(style, base), pick_coord(style, base),
                  pick_coord(style, base), pick_coord(style, base),
                  pick_coord(style, base), pick_coord(style, base),
                  pick_param()), unknown);
    end

    req_ch.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_halves.size() != 0) begin
      $error("%0d results never arrived", expected_halves.size());
      mismatches++;
    end

    $display("Split %0d curves: %0d table rows, %0d random, %0d with t clamped to one.",
             items_sent, split_table.size(), RANDOM_SPLITS, saturated_splits);
    $display("Included a %0d-cycle result stall and a full drain mid-run; %0d mismatches.",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("tb_cubic_bezier_split: done, clean");
    end else begin
      $display("tb_cubic_bezier_split: done, errors");
    end
    $finish;
  end

endmodule

>>> cubic_bezier_split.f
src/cbs_pkg.sv
src/cbs_in_if.sv
src/cbs_out_if.sv
src/cbs_lerp.sv
src/cbs_ctrl.sv
src/cubic_bezier_split.sv
tb/tb_cubic_bezier_split.sv
